// ----- rtl/voxel_ray_traversal_assert.svh -----
// assertion macros for the voxel ray traversal block
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`ifndef SYNTHESIS
`define VRT_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define VRT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define VRT_ASSERT_IMPL(label, clk, rst_n, a, c)
`define VRT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/vrt_pkg.sv -----
// package: types, constants and codes for the voxel ray traversal block
`default_nettype none
package vrt_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int INT_BITS_DEF  = 16;
    localparam logic [31:0] NEVER = 32'hFFFF_FFFF;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_REPLY = 1'b1;
    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;
    localparam logic [2:0] FACE_NONE  = 3'd6;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic        [31:0] max_dist;
        logic               occupied;
    } in_word_t;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [15:0] voxel_x;
        logic signed [15:0] voxel_y;
        logic signed [15:0] voxel_z;
        logic        [2:0]  face;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_START_EMIT,
        ST_STEP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load_start;
        logic       sqrt_go;
        logic       div_load;
        logic       div_store;
        logic [2:0] div_idx;
        logic       do_step;
        logic       do_hit;
        logic       out_load;
        logic [1:0] out_kind;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic dir_zero;
        logic step_miss;
    } status_t;
endpackage
`default_nettype wire

// ----- rtl/vrt_ctrl.sv -----
// controller state machine for the voxel ray traversal block
`default_nettype none
module vrt_ctrl
    import vrt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    in_cmd,
    input  wire logic    in_occ,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cmd_t         cmd,
    input  wire status_t status
);
    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       active_reg, active_next;
    logic       ov_reg, ov_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
            kind_reg   <= KIND_QUERY;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
            kind_reg   <= kind_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        ov_next     = ov_reg;
        kind_next   = kind_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !ov_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    if (in_cmd == CMD_START)
                    begin
                        cmd.load_start = 1'b1;
                        cmd.sqrt_go    = 1'b1;
                        state_next     = ST_SQRT;
                    end
                    else if (active_reg)
                    begin
                        if (in_occ)
                        begin
                            cmd.do_hit   = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_HIT;
                            ov_next      = 1'b1;
                            active_next  = 1'b0;
                        end
                        else
                            state_next = ST_STEP;
                    end
                end
            end
            ST_SQRT:
            begin
                idx_next = '0;
                if (status.sqrt_done)
                    state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_idx  = idx_reg;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_idx = idx_reg;
                if (status.div_done)
                    state_next = ST_DIV_STORE;
            end
            ST_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                cmd.div_idx   = idx_reg;
                if (idx_reg == 3'd5)
                    state_next = ST_START_EMIT;
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_START_EMIT:
            begin
                state_next = ST_OUT;
                cmd.out_kind = status.dir_zero ? KIND_MISS : KIND_QUERY;
                kind_next    = cmd.out_kind;
                active_next  = !status.dir_zero;
            end
            ST_STEP:
            begin
                cmd.do_step  = !status.step_miss;
                cmd.out_kind = status.step_miss ? KIND_MISS : KIND_QUERY;
                kind_next    = cmd.out_kind;
                active_next  = !status.step_miss;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_kind = kind_reg;
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/vrt_datapath.sv -----
// datapath: setup root and divider, per-axis crossing registers, result word
`default_nettype none
module vrt_datapath
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int INT_BITS  = INT_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t in_word,
    input  wire cmd_t     cmd,
    input  wire logic [1:0] kind_q,
    output status_t       status,
    output out_word_t     out_word
);
    localparam int NUM_W = 48 + 24;
    localparam int DEN_W = 32;

    logic [INT_BITS-1:0] cell_reg [3];
    logic [1:0]          sign_reg [3];
    logic [31:0]         cross_reg [3];
    logic [31:0]         delta_reg [3];
    logic [FRAC_BITS:0]  frac_reg [3];
    logic [31:0]         limit_reg;
    logic [2:0]          face_reg;
    logic [49:0]         len_reg;
    out_word_t           out_reg;

    // square root of s * 2^32, computed bit-serially
    logic [65:0] rem_reg;
    logic [33:0] root_reg;
    logic [65:0] rad_reg;
    logic [5:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic [33:0] s_c;
    logic signed [31:0] px, py, pz;

    assign px  = in_word.dir_x * in_word.dir_x;
    assign py  = in_word.dir_y * in_word.dir_y;
    assign pz  = in_word.dir_z * in_word.dir_z;
    assign s_c = 34'(unsigned'(px)) + 34'(unsigned'(py)) + 34'(unsigned'(pz));

    logic [65:0] trial;
    logic [65:0] rem_sh;
    assign rem_sh = {rem_reg[63:0], rad_reg[65:64]};
    assign trial  = {30'd0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else if (cmd.sqrt_go)
        begin
            sq_busy_reg <= 1'b1;
            sq_cnt_reg  <= 6'd33;
        end
        else if (sq_busy_reg)
        begin
            if (sq_cnt_reg == 6'd0)
                sq_busy_reg <= 1'b0;
            else
                sq_cnt_reg <= sq_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_go)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= {s_c, 32'd0};
        end
        else if (sq_busy_reg && sq_cnt_reg != 6'd0)
        begin
            rad_reg <= {rad_reg[63:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[32:0], 1'b0};
            end
        end
    end
    assign status.sqrt_done = sq_busy_reg && sq_cnt_reg == 6'd0;

    // restoring divider, one quotient bit a cycle
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [6:0]       dv_cnt_reg;
    logic             dv_busy_reg;
    logic [1:0]       ax;
    logic             is_delta;
    logic signed [15:0] dsel;
    logic [15:0]      ad;
    logic [NUM_W-1:0] num_c;
    logic [DEN_W:0]   r_sh;

    assign ax       = (cmd.div_idx >= 3'd3) ? 2'(cmd.div_idx - 3'd3) : cmd.div_idx[1:0];
    assign is_delta = cmd.div_idx >= 3'd3;
    always_comb
    begin
        case (ax)
            2'd0:    dsel = in_word.dir_x;
            2'd1:    dsel = in_word.dir_y;
            default: dsel = in_word.dir_z;
        endcase
    end
    assign ad = dsel[15] ? 16'(-dsel) : dsel;
    assign num_c = is_delta ? (NUM_W'(len_reg) << FRAC_BITS)
                            : NUM_W'(frac_reg[ax] * len_reg);
    assign r_sh  = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else if (cmd.div_load)
        begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg  <= 7'(NUM_W);
        end
        else if (dv_busy_reg && dv_cnt_reg != 7'd0)
            dv_cnt_reg <= dv_cnt_reg - 7'd1;
        else
            dv_busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            q_reg <= num_c;
            r_reg <= '0;
            d_reg <= {ad, 16'd0};
        end
        else if (dv_busy_reg && dv_cnt_reg != 7'd0)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_reg <= r_sh - {1'b0, d_reg};
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end
    assign status.div_done = dv_busy_reg && dv_cnt_reg == 7'd0;

    logic [31:0] q_sat;
    assign q_sat = (q_reg[NUM_W-1:32] != '0) ? NEVER : q_reg[31:0];
    assign status.dir_zero = (len_reg == '0);

    // axis choice and step
    logic [1:0]  sel;
    logic [32:0] sum;
    always_comb
    begin
        if (cross_reg[0] < cross_reg[1])
            sel = (cross_reg[0] < cross_reg[2]) ? 2'd0 : 2'd2;
        else
            sel = (cross_reg[1] < cross_reg[2]) ? 2'd1 : 2'd2;
    end
    assign sum = {1'b0, cross_reg[sel]} + {1'b0, delta_reg[sel]};
    assign status.step_miss = cross_reg[sel] == NEVER || cross_reg[sel] > limit_reg;

    logic [47:0] o_c [3];
    assign o_c[0] = 48'(in_word.origin_x);
    assign o_c[1] = 48'(in_word.origin_y);
    assign o_c[2] = 48'(in_word.origin_z);
    logic signed [15:0] dv_c [3];
    assign dv_c[0] = in_word.dir_x;
    assign dv_c[1] = in_word.dir_y;
    assign dv_c[2] = in_word.dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cell_reg[i]  <= '0;
                sign_reg[i]  <= SIGN_NONE;
                cross_reg[i] <= '0;
                delta_reg[i] <= '0;
                frac_reg[i]  <= '0;
            end
            limit_reg <= '0;
            face_reg  <= FACE_NONE;
            len_reg   <= '0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                limit_reg <= in_word.max_dist;
                face_reg  <= FACE_NONE;
                for (int i = 0; i < 3; i++)
                begin
                    cell_reg[i] <= o_c[i][FRAC_BITS +: INT_BITS];
                    if (dv_c[i] == 16'sd0)
                        sign_reg[i] <= SIGN_NONE;
                    else
                        sign_reg[i] <= dv_c[i][15] ? SIGN_MINUS : SIGN_PLUS;
                    if (dv_c[i][15])
                        frac_reg[i] <= {1'b0, o_c[i][FRAC_BITS-1:0]};
                    else
                        frac_reg[i] <= (FRAC_BITS+1)'(1 << FRAC_BITS)
                                       - {1'b0, o_c[i][FRAC_BITS-1:0]};
                end
            end
            if (status.sqrt_done)
                len_reg <= root_reg[33:0] == '0 ? '0 : 50'(root_reg);
            if (cmd.div_store)
            begin
                if (sign_reg[ax] == SIGN_NONE)
                begin
                    if (is_delta)
                        delta_reg[ax] <= NEVER;
                    else
                        cross_reg[ax] <= NEVER;
                end
                else if (is_delta)
                    delta_reg[ax] <= q_sat;
                else
                    cross_reg[ax] <= q_sat;
            end
            if (cmd.do_step)
            begin
                if (sign_reg[sel] == SIGN_PLUS)
                    cell_reg[sel] <= cell_reg[sel] + INT_BITS'(1);
                else if (sign_reg[sel] == SIGN_MINUS)
                    cell_reg[sel] <= cell_reg[sel] - INT_BITS'(1);
                cross_reg[sel] <= sum[32] ? NEVER : sum[31:0];
                face_reg <= {sel, 1'b0} + ((sign_reg[sel] == SIGN_PLUS) ? 3'd0 : 3'd1);
            end
        end
    end

    logic signed [15:0] vx, vy, vz;
    assign vx = 16'(signed'(cell_reg[0]));
    assign vy = 16'(signed'(cell_reg[1]));
    assign vz = 16'(signed'(cell_reg[2]));

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.kind <= kind_q;
            out_reg.face <= (kind_q == KIND_HIT) ? face_reg : FACE_NONE;
            if (kind_q == KIND_MISS)
            begin
                out_reg.voxel_x <= '0;
                out_reg.voxel_y <= '0;
                out_reg.voxel_z <= '0;
            end
            else
            begin
                out_reg.voxel_x <= vx;
                out_reg.voxel_y <= vy;
                out_reg.voxel_z <= vz;
            end
        end
    end
    assign out_word = out_reg;
endmodule
`default_nettype wire

// ----- rtl/voxel_ray_traversal.sv -----
// top level of the voxel ray traversal block
`default_nettype none
`include "voxel_ray_traversal_assert.svh"
// Voxel ray traversal (3D DDA). A start word computes the length root and
// six divisions on one shared bit-serial divider, then yields a query of
// the origin voxel, or a miss if the direction is zero. A reply word for
// an empty voxel yields a query or a miss (compare of three crossings and
// one add, then the result register); an occupied reply yields its hit in
// the cycle after it is taken. A result that waits for out_ready holds off
// the input. Replies with no active ray are dropped without a result.
module voxel_ray_traversal
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int INT_BITS  = INT_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_word_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_word_t     out_data
);
    cmd_t    cmd;
    status_t status;
    in_word_t in_hold_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_hold_reg <= in_data;
    end

    in_word_t dp_in;
    logic [1:0] kind_q;
    assign dp_in  = cmd.load_start || cmd.do_hit ? in_data : in_hold_reg;
    assign kind_q = cmd.out_kind;

    vrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_data.cmd),
        .in_occ    (in_data.occupied),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    vrt_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (dp_in),
        .cmd      (cmd),
        .kind_q   (kind_q),
        .status   (status),
        .out_word (out_data)
    );

    `VRT_ASSERT_IMPL(a_miss_no_cell, clk, rst_n,
        out_valid && out_data.kind == KIND_MISS, out_data.voxel_x == 16'sd0)
    `VRT_ASSERT_IMPL(a_query_face, clk, rst_n,
        out_valid && out_data.kind == KIND_QUERY, out_data.face == FACE_NONE)
    `VRT_ASSERT_NEXT(a_out_hold, clk, rst_n,
        out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

// ----- tb/sv/voxel_ray_traversal_test.sv -----
// testbench for the voxel ray traversal block: directed and random rays checked by a DDA predictor
module voxel_ray_traversal_test;
    import vrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;

    voxel_ray_traversal u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    in_word_t pending_words[$];
    out_word_t expected_words[$];
    int mismatches = 0;
    int words_taken = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic calm;

    // ray state of the predictor
    logic [15:0] ray_cell[3];
    logic [1:0] ray_sign[3];
    logic [31:0] ray_next[3];
    logic [31:0] ray_delta[3];
    logic [31:0] ray_limit;
    logic [2:0] ray_face;
    bit ray_live;

    assign calm = pending_words.size() < 50;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? NEVER : v[31:0];
    endfunction

    function automatic out_word_t make_out(logic [1:0] k, bit with_cell, logic [2:0] f);
        out_word_t w;
        w.kind = k;
        w.voxel_x = with_cell ? ray_cell[0] : 16'd0;
        w.voxel_y = with_cell ? ray_cell[1] : 16'd0;
        w.voxel_z = with_cell ? ray_cell[2] : 16'd0;
        w.face = f;
        return w;
    endfunction

    task automatic trace_ray(in_word_t w);
        logic signed [15:0] dv[3];
        logic [31:0] ov[3];
        longint signed d;
        longint unsigned s;
        longint unsigned len;
        longint unsigned den;
        longint unsigned frac;
        int ax;
        dv[0] = w.dir_x;
        dv[1] = w.dir_y;
        dv[2] = w.dir_z;
        ov[0] = w.origin_x;
        ov[1] = w.origin_y;
        ov[2] = w.origin_z;
        if (w.cmd == CMD_START)
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                d = dv[i];
                s = s + longint'(d * d);
            end
            len = int_sqrt(s << 32);
            ray_limit = w.max_dist;
            ray_face = FACE_NONE;
            for (int i = 0; i < 3; i++)
            begin
                d = dv[i];
                ray_cell[i] = ov[i][31:16];
                if (d == 0)
                begin
                    ray_sign[i] = SIGN_NONE;
                    ray_next[i] = NEVER;
                    ray_delta[i] = NEVER;
                end
                else
                begin
                    den = longint'(d < 0 ? -d : d) << 16;
                    frac = (d > 0) ? (64'd65536 - ov[i][15:0]) : ov[i][15:0];
                    ray_sign[i] = (d > 0) ? SIGN_PLUS : SIGN_MINUS;
                    ray_delta[i] = clamp32((len << 16) / den);
                    ray_next[i] = clamp32((frac * len) / den);
                end
            end
            if (s == 0)
            begin
                ray_live = 1'b0;
                expected_words.push_back(make_out(KIND_MISS, 1'b0, FACE_NONE));
            end
            else
            begin
                ray_live = 1'b1;
                expected_words.push_back(make_out(KIND_QUERY, 1'b1, FACE_NONE));
            end
        end
        else if (ray_live)
        begin
            if (w.occupied)
            begin
                ray_live = 1'b0;
                expected_words.push_back(make_out(KIND_HIT, 1'b1, ray_face));
            end
            else
            begin
                if (ray_next[0] < ray_next[1])
                    ax = (ray_next[0] < ray_next[2]) ? 0 : 2;
                else
                    ax = (ray_next[1] < ray_next[2]) ? 1 : 2;
                if (ray_next[ax] == NEVER || ray_next[ax] > ray_limit)
                begin
                    ray_live = 1'b0;
                    expected_words.push_back(make_out(KIND_MISS, 1'b0, FACE_NONE));
                end
                else
                begin
                    if (ray_sign[ax] == SIGN_PLUS)
                        ray_cell[ax] = ray_cell[ax] + 16'd1;
                    else if (ray_sign[ax] == SIGN_MINUS)
                        ray_cell[ax] = ray_cell[ax] - 16'd1;
                    ray_next[ax] = clamp32(longint'(ray_next[ax]) + longint'(ray_delta[ax]));
                    ray_face = 3'(2 * ax + ((ray_sign[ax] == SIGN_PLUS) ? 0 : 1));
                    expected_words.push_back(make_out(KIND_QUERY, 1'b1, FACE_NONE));
                end
            end
        end
    endtask

    function automatic in_word_t start_word(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                            logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                                            logic [31:0] md);
        in_word_t w;
        w.cmd = CMD_START;
        w.origin_x = ox;
        w.origin_y = oy;
        w.origin_z = oz;
        w.dir_x = dx;
        w.dir_y = dy;
        w.dir_z = dz;
        w.max_dist = md;
        w.occupied = 1'($urandom);
        return w;
    endfunction

    function automatic in_word_t reply_word(bit occ);
        in_word_t w;
        w = start_word($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                       16'($urandom), $urandom);
        w.cmd = CMD_REPLY;
        w.occupied = occ;
        return w;
    endfunction

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {16'($signed($urandom_range(0, 64)) - 32), 16'd0};
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return NEVER;
            2: return 32'd0;
            default: return $urandom_range(0, 32'h000C_0000);
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                in_data <= pending_words.pop_front();
                in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    gap_left <= $urandom_range(1, 11);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && words_taken >= 120)
        begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && in_valid && in_ready)
        begin
            words_taken <= words_taken + 1;
            trace_ray(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", out_data);
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_data.kind !== e.kind || out_data.voxel_x !== e.voxel_x
                    || out_data.voxel_y !== e.voxel_y || out_data.voxel_z !== e.voxel_z
                    || out_data.face !== e.face)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, out_data);
                end
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int budget;
        int nrep;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        pending_words.push_back(reply_word(1'b0));
        pending_words.push_back(start_word(32'h0001_8000, 32'h0, 32'hFFFF_0000, 16'd0, 16'd0,
                                           16'd0, NEVER));
        pending_words.push_back(reply_word(1'b0));
        pending_words.push_back(start_word(32'h0005_0000, 32'h0002_0000, 32'h0, 16'h7FFF,
                                           16'd0, 16'd0, 32'h0003_0000));
        repeat (4) pending_words.push_back(reply_word(1'b0));
        pending_words.push_back(start_word(32'h0000_4000, 32'h0, 32'h0, 16'd100, 16'd50,
                                           16'd25, NEVER));
        pending_words.push_back(reply_word(1'b1));
        pending_words.push_back(start_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                           16'h8000, 16'h8000, 16'h8000, NEVER));
        repeat (3) pending_words.push_back(reply_word(1'b0));
        pending_words.push_back(reply_word(1'b1));
        pending_words.push_back(start_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           16'd1, 16'h8000, 16'h8000, NEVER));
        repeat (4) pending_words.push_back(reply_word(1'b0));
        pending_words.push_back(start_word(32'h0, 32'h0, 32'h0, 16'd0, 16'hC000, 16'd0, 32'd0));
        pending_words.push_back(start_word(32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 16'd3, 16'd4,
                                           16'd0, 32'h0010_0000));
        pending_words.push_back(reply_word(1'b0));
        pending_words.push_back(reply_word(1'b1));

        budget = 600;
        while (budget > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_words.push_back(reply_word($urandom_range(0, 1)));
            if ($urandom_range(0, 19) == 0)
            begin
                dx = 16'd0;
                dy = 16'd0;
                dz = 16'd0;
            end
            else
            begin
                dx = rand_dir();
                dy = rand_dir();
                dz = rand_dir();
            end
            pending_words.push_back(start_word(rand_origin(), rand_origin(), rand_origin(),
                                               dx, dy, dz, rand_limit()));
            nrep = $urandom_range(1, 20);
            for (int i = 0; i < nrep; i++)
                pending_words.push_back(reply_word($urandom_range(0, 11) == 0));
            budget = budget - 1 - nrep;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/vrt_pkg.sv
rtl/vrt_ctrl.sv
rtl/vrt_datapath.sv
rtl/voxel_ray_traversal.sv
tb/sv/voxel_ray_traversal_test.sv
